// File: src/ipc_pkg.sv
`timescale 1ns / 1ps
package ipc_pkg;
    localparam int POLICY_DEPTH = 16;
    localparam int IDX_W = $clog2(POLICY_DEPTH);
    localparam int CNT_W = $clog2(POLICY_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_STAGE  = 2'd1,
        OP_APPEND = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;
    localparam logic [1:0] ACT_PROTECT = 2'd2;

    typedef struct packed {
        logic         ipv6;
        logic [7:0]   proto;
        logic [127:0] src_lo;
        logic [127:0] src_hi;
        logic [127:0] dst_lo;
        logic [127:0] dst_hi;
        logic [15:0]  sport_lo;
        logic [15:0]  sport_hi;
        logic [15:0]  dport_lo;
        logic [15:0]  dport_hi;
        logic [1:0]   act;
        logic [31:0]  spi;
    } policy_t;

    typedef struct packed {
        logic         ipv6;
        logic [7:0]   proto;
        logic [127:0] src;
        logic [127:0] dst;
        logic [15:0]  sport;
        logic [15:0]  dport;
    } flow_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic [1:0]       act;
        logic [31:0]      spi;
    } hit_t;
endpackage

// File: src/ipc_cell.sv
`timescale 1ns / 1ps
module ipc_cell import ipc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  policy_t          wr_pol,
    input  logic             valid,
    input  logic [IDX_W-1:0] my_idx,
    input  flow_t            flow_in,
    input  hit_t             hit_in,
    output flow_t            flow_out,
    output hit_t             hit_out
);
    policy_t pol_reg;
    flow_t   flow_reg;
    hit_t    hit_reg;
    logic    match;
    logic [127:0] m;

    assign m = flow_in.ipv6 ? {128{1'b1}} : {96'd0, 32'hFFFF_FFFF};

    always_comb begin
        match = valid && pol_reg.ipv6 == flow_in.ipv6
            && (pol_reg.proto == 8'd0 || pol_reg.proto == flow_in.proto)
            && (flow_in.src & m) >= (pol_reg.src_lo & m)
            && (flow_in.src & m) <= (pol_reg.src_hi & m)
            && (flow_in.dst & m) >= (pol_reg.dst_lo & m)
            && (flow_in.dst & m) <= (pol_reg.dst_hi & m)
            && flow_in.sport >= pol_reg.sport_lo && flow_in.sport <= pol_reg.sport_hi
            && flow_in.dport >= pol_reg.dport_lo && flow_in.dport <= pol_reg.dport_hi;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pol_reg <= wr_pol;
        end
        flow_reg <= flow_in;
        if (!aresetn) begin
            hit_reg <= '0;
        end else if (!hit_in.hit && match) begin
            hit_reg <= '{hit: 1'b1, idx: my_idx, act: pol_reg.act, spi: pol_reg.spi};
        end else begin
            hit_reg <= hit_in;
        end
    end

    assign flow_out = flow_reg;
    assign hit_out  = hit_reg;
endmodule

// File: src/ipsec_policy_classifier.sv
`timescale 1ns / 1ps
// Timing: clear, stage and append give their result in the cycle after the word is taken;
// a lookup walks the chain of POLICY_DEPTH compare cells, one cell per cycle, and its
// result is registered after the last cell. One word in flight: the next word is taken
// only once the result of the last has been taken, so a held result blocks the next word.
// Reset: aresetn, synchronous, active low, empties the table and the staged bounds.
module ipsec_policy_classifier import ipc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation, ipv6, protocol, src_addr_high, src_addr_low, dst_addr_high,
    // dst_addr_low, sport, dport, action, spi, zero fill
    input  logic [335:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, match_index, matched_action, matched_spi
    output logic [39:0]  m_tdata
);
    logic [1:0]   op;
    flow_t        fl;
    logic [1:0]   act_in;
    logic [31:0]  spi_in;
    logic [CNT_W-1:0] count_reg;
    logic [127:0] st_src_reg, st_dst_reg;
    logic [15:0]  st_sp_reg, st_dp_reg;
    logic         busy_reg, walk_reg;
    logic [CNT_W-1:0] step_reg;
    logic         out_valid_reg;
    logic [39:0]  out_reg;
    policy_t      newpol;
    flow_t        fchain [POLICY_DEPTH+1];
    hit_t         hchain [POLICY_DEPTH+1];
    logic [POLICY_DEPTH-1:0] wr;
    logic         acc;

    assign op     = s_tdata[1:0];
    assign fl     = '{ipv6: s_tdata[2], proto: s_tdata[10:3],
                      src: {s_tdata[74:11], s_tdata[138:75]},
                      dst: {s_tdata[202:139], s_tdata[266:203]},
                      sport: s_tdata[282:267], dport: s_tdata[298:283]};
    assign act_in = s_tdata[300:299];
    assign spi_in = s_tdata[332:301];

    assign s_tready = !busy_reg && !out_valid_reg;
    assign acc = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    assign newpol = '{ipv6: fl.ipv6, proto: fl.proto, src_lo: st_src_reg, src_hi: fl.src,
                      dst_lo: st_dst_reg, dst_hi: fl.dst, sport_lo: st_sp_reg,
                      sport_hi: fl.sport, dport_lo: st_dp_reg, dport_hi: fl.dport,
                      act: act_in, spi: (act_in == ACT_PROTECT) ? spi_in : 32'd0};

    assign fchain[0] = fl;
    assign hchain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < POLICY_DEPTH; g++) begin : g_cell
            assign wr[g] = acc && op == OP_APPEND && count_reg == CNT_W'(g);
            ipc_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .wr_en(wr[g]), .wr_pol(newpol),
                .valid(count_reg > CNT_W'(g)), .my_idx(IDX_W'(g)),
                .flow_in(fchain[g]), .hit_in(hchain[g]),
                .flow_out(fchain[g+1]), .hit_out(hchain[g+1])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            walk_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            st_src_reg    <= '0;
            st_dst_reg    <= '0;
            st_sp_reg     <= '0;
            st_dp_reg     <= '0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (walk_reg) begin
                if (step_reg == CNT_W'(POLICY_DEPTH - 1)) begin
                    walk_reg <= 1'b0;
                    busy_reg <= 1'b0;
                    out_valid_reg <= 1'b1;
                    out_reg <= hchain[POLICY_DEPTH].hit
                        ? {hchain[POLICY_DEPTH].spi, hchain[POLICY_DEPTH].act,
                           4'(hchain[POLICY_DEPTH].idx), ST_DONE}
                        : {38'd0, ST_NOMATCH};
                end
                step_reg <= step_reg + 1'b1;
            end
            if (acc) begin
                unique case (op)
                    OP_CLEAR: begin
                        count_reg <= '0;
                        out_valid_reg <= 1'b1;
                        out_reg <= '0;
                    end
                    OP_STAGE: begin
                        st_src_reg <= fl.src;
                        st_dst_reg <= fl.dst;
                        st_sp_reg  <= fl.sport;
                        st_dp_reg  <= fl.dport;
                        out_valid_reg <= 1'b1;
                        out_reg <= '0;
                    end
                    OP_APPEND: begin
                        out_valid_reg <= 1'b1;
                        if (count_reg == CNT_W'(POLICY_DEPTH)) begin
                            out_reg <= {38'd0, ST_FULL};
                        end else begin
                            out_reg <= {34'd0, 4'(count_reg), ST_DONE};
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    default: begin
                        busy_reg <= 1'b1;
                        walk_reg <= 1'b1;
                        step_reg <= '0;
                    end
                endcase
            end
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_tready) else $error("accept while busy");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(POLICY_DEPTH)) else $error("count overflow");
    a_walk_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_reg |-> busy_reg && !out_valid_reg) else $error("walk state");
endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import ipc_pkg::*;

    localparam int RANDOM_WORDS = 1750;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        op_t          op;
        bit           v6;
        bit [7:0]     proto;
        bit [127:0]   saddr;
        bit [127:0]   daddr;
        bit [15:0]    sport;
        bit [15:0]    dport;
        bit [1:0]     act;
        bit [31:0]    spi;
    } word_t;

    typedef struct {
        bit [1:0]  status;
        bit [3:0]  idx;
        bit [1:0]  act;
        bit [31:0] spi;
    } verdict_t;

    typedef struct {
        word_t    w;
        bit       typed;
        verdict_t want;
    } row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [335:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;

    ipsec_policy_classifier dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    policy_t    policies [POLICY_DEPTH];
    int         n_policies;
    bit [127:0] staged_src;
    bit [127:0] staged_dst;
    bit [15:0]  staged_sport;
    bit [15:0]  staged_dport;

    verdict_t   pending_verdicts[$];
    int         errors;
    int         cycles;
    int         n_hits;
    int         n_misses;
    int         n_full;
    int         n_words;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("ipsec_policy_classifier regression: fail");
            $finish;
        end
    end

    function automatic bit [127:0] rnd128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic bit addr_in(bit v6, bit [127:0] a, bit [127:0] lo, bit [127:0] hi);
        if (!v6) begin
            return a[31:0] >= lo[31:0] && a[31:0] <= hi[31:0];
        end
        return a >= lo && a <= hi;
    endfunction

    function automatic verdict_t classify(word_t w);
        verdict_t r;
        policy_t  p;
        r = '{default: 0};
        case (w.op)
            OP_CLEAR: begin
                n_policies = 0;
            end
            OP_STAGE: begin
                staged_src   = w.saddr;
                staged_dst   = w.daddr;
                staged_sport = w.sport;
                staged_dport = w.dport;
            end
            OP_APPEND: begin
                if (n_policies >= POLICY_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    p.ipv6     = w.v6;
                    p.proto    = w.proto;
                    p.src_lo   = staged_src;
                    p.src_hi   = w.saddr;
                    p.dst_lo   = staged_dst;
                    p.dst_hi   = w.daddr;
                    p.sport_lo = staged_sport;
                    p.sport_hi = w.sport;
                    p.dport_lo = staged_dport;
                    p.dport_hi = w.dport;
                    p.act      = w.act;
                    p.spi      = (w.act == ACT_PROTECT) ? w.spi : 32'd0;
                    policies[n_policies] = p;
                    r.idx = n_policies[3:0];
                    n_policies++;
                end
            end
            default: begin
                r.status = ST_NOMATCH;
                for (int i = 0; i < n_policies; i++) begin
                    p = policies[i];
                    if (p.ipv6 == w.v6 && (p.proto == 0 || p.proto == w.proto)
                        && addr_in(w.v6, w.saddr, p.src_lo, p.src_hi)
                        && addr_in(w.v6, w.daddr, p.dst_lo, p.dst_hi)
                        && w.sport >= p.sport_lo && w.sport <= p.sport_hi
                        && w.dport >= p.dport_lo && w.dport <= p.dport_hi) begin
                        r.status = ST_DONE;
                        r.idx    = i[3:0];
                        r.act    = p.act;
                        r.spi    = p.spi;
                        break;
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    endtask

    task automatic send_word(word_t w, bit typed, verdict_t want);
        int       gap;
        verdict_t v;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'd0, w.spi, w.act, w.dport, w.sport, w.daddr[63:0], w.daddr[127:64],
                     w.saddr[63:0], w.saddr[127:64], w.proto, w.v6, w.op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        v = classify(w);
        if (w.op == OP_LOOKUP) begin
            if (v.status == ST_DONE) n_hits++;
            else n_misses++;
        end
        if (v.status == ST_FULL) n_full++;
        n_words++;
        pending_verdicts.push_back(typed ? want : v);
    endtask

    initial begin
        int       stall;
        verdict_t got;
        verdict_t want;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got.status = m_tdata[1:0];
            got.idx    = m_tdata[5:2];
            got.act    = m_tdata[7:6];
            got.spi    = m_tdata[39:8];
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, 0);
            end else begin
                want = pending_verdicts.pop_front();
                if (got.status != want.status) report_mismatch("status", got.status, want.status);
                if (got.idx != want.idx) report_mismatch("match_index", got.idx, want.idx);
                if (got.act != want.act) report_mismatch("matched_action", got.act, want.act);
                if (got.spi != want.spi) report_mismatch("matched_spi", got.spi, want.spi);
            end
        end
    end

    function automatic word_t blank(op_t op);
        word_t w;
        w = '{op: op, default: 0};
        return w;
    endfunction

    function automatic word_t noise(op_t op);
        word_t w;
        w.op    = op;
        w.v6    = 1'($urandom_range(0, 1));
        w.proto = 8'($urandom);
        w.saddr = rnd128();
        w.daddr = rnd128();
        w.sport = 16'($urandom);
        w.dport = 16'($urandom);
        w.act   = 2'($urandom);
        w.spi   = $urandom;
        return w;
    endfunction

    task automatic make_range(bit v6, output bit [127:0] lo, output bit [127:0] hi);
        bit [127:0] m;
        bit [127:0] d;
        m  = v6 ? '1 : 128'hffff_ffff;
        lo = rnd128() & m;
        case ($urandom_range(0, 3))
            0: d = 0;
            1: d = 128'($urandom_range(0, 255));
            2: d = rnd128() & (m >> $urandom_range(1, 100));
            default: begin
                lo = 0;
                d  = m;
            end
        endcase
        hi = lo + d;
        if (hi > m || hi < lo) hi = m;
        if (!v6) begin
            lo[127:32] = 96'(rnd128());
            hi[127:32] = 96'(rnd128());
        end
    endtask

    function automatic bit [127:0] pick_within(bit v6, bit [127:0] lo, bit [127:0] hi);
        bit [127:0] a;
        bit [127:0] l;
        bit [127:0] h;
        l = v6 ? lo : 128'(lo[31:0]);
        h = v6 ? hi : 128'(hi[31:0]);
        case ($urandom_range(0, 4))
            0: a = l;
            1: a = h;
            2: a = (h >= l) ? l + ((h - l) >> 1) : rnd128();
            3: a = (h >= l) ? h + 1 : l - 1;
            default: a = rnd128();
        endcase
        if (!v6) a[127:32] = 96'(rnd128());
        return a;
    endfunction

    task automatic add_policy();
        word_t      st;
        word_t      ap;
        bit [127:0] lo;
        bit [127:0] hi;
        bit [15:0]  plo;
        bit [15:0]  phi;
        st = noise(OP_STAGE);
        ap = noise(OP_APPEND);
        make_range(ap.v6, lo, hi);
        st.saddr = lo;
        ap.saddr = hi;
        make_range(ap.v6, lo, hi);
        st.daddr = lo;
        ap.daddr = hi;
        plo = 16'($urandom);
        phi = 16'(plo + $urandom_range(0, 2000));
        if (phi < plo) phi = 16'hffff;
        st.sport = plo;
        ap.sport = phi;
        plo = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom);
        phi = $urandom_range(0, 3) == 0 ? 16'hffff : plo + 16'($urandom_range(0, 500));
        if (phi < plo) phi = 16'hffff;
        st.dport = plo;
        ap.dport = phi;
        if ($urandom_range(0, 1)) ap.proto = 0;
        send_word(st, 0, '{default: 0});
        send_word(ap, 0, '{default: 0});
    endtask

    task automatic targeted_lookup();
        word_t   w;
        policy_t p;
        w = noise(OP_LOOKUP);
        if (n_policies > 0 && $urandom_range(0, 4) != 0) begin
            p = policies[$urandom_range(0, n_policies - 1)];
            w.v6 = p.ipv6;
            if (p.proto != 0 && $urandom_range(0, 5) != 0) w.proto = p.proto;
            w.saddr = pick_within(p.ipv6, p.src_lo, p.src_hi);
            w.daddr = pick_within(p.ipv6, p.dst_lo, p.dst_hi);
            w.sport = $urandom_range(0, 4) == 0 ? 16'($urandom)
                      : 16'($urandom_range(p.sport_lo, p.sport_hi));
            w.dport = $urandom_range(0, 4) == 0 ? 16'($urandom)
                      : 16'($urandom_range(p.dport_lo, p.dport_hi));
        end
        send_word(w, 0, '{default: 0});
    endtask

    initial begin
        row_t  rows[$];
        row_t  r;
        word_t w;
        int    k;
        bit    drained;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        aresetn    = 1'b0;
        errors     = 0;
        cycles     = 0;
        n_hits     = 0;
        n_misses   = 0;
        n_full     = 0;
        n_words    = 0;
        drained    = 0;
        n_policies = 0;
        staged_src = 0;
        staged_dst = 0;
        staged_sport = 0;
        staged_dport = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Lookup on an empty table misses.
        r = '{w: blank(OP_LOOKUP), typed: 1, want: '{ST_NOMATCH, 0, 0, 0}};
        rows.push_back(r);
        // Append with nothing staged: the lower bounds are zero, and the SPI is dropped for action 0.
        w = blank(OP_APPEND);
        w.saddr = '1; w.daddr = '1; w.sport = '1; w.dport = '1; w.spi = '1;
        r = '{w: w, typed: 1, want: '{ST_DONE, 0, 0, 0}};
        rows.push_back(r);
        // IPv4 lookup with junk in the upper address bits still hits.
        w = blank(OP_LOOKUP);
        w.saddr = {96'hffff_ffff_ffff_ffff_ffff_ffff, 32'h0};
        w.daddr = '1; w.sport = '1; w.proto = 8'hff;
        r = '{w: w, typed: 1, want: '{ST_DONE, 0, 0, 0}};
        rows.push_back(r);
        r = '{w: blank(OP_LOOKUP), typed: 1, want: '{ST_NOMATCH, 0, 0, 0}};
        r.w.v6 = 1;
        rows.push_back(r);
        w = blank(OP_STAGE);
        w.v6 = 1; w.saddr = {64'h1, 64'h0}; w.daddr = {64'h0, 64'hffff_ffff_ffff_ffff};
        w.sport = 16'd100; w.dport = 16'd500;
        r = '{w: w, typed: 0, want: '{default: 0}};
        rows.push_back(r);
        w.op = OP_APPEND; w.proto = 8'd6; w.saddr = {64'h1, 64'hffff_ffff_ffff_ffff};
        w.daddr = {64'h1, 64'h0}; w.sport = 16'd200; w.dport = 16'd500;
        w.act = ACT_PROTECT; w.spi = 32'hdead_beef;
        rows.push_back('{w: w, typed: 0, want: '{default: 0}});
        w.op = OP_LOOKUP; w.saddr = {64'h1, 64'h8000}; w.daddr = {64'h0, 64'hffff_ffff_ffff_ffff};
        w.sport = 16'd200;
        rows.push_back('{w: w, typed: 0, want: '{default: 0}});
        w.proto = 8'd17;
        rows.push_back('{w: w, typed: 0, want: '{default: 0}});
        w = blank(OP_STAGE);
        w.v6 = 1;
        rows.push_back('{w: w, typed: 0, want: '{default: 0}});
        w.op = OP_APPEND; w.saddr = '1; w.daddr = '1; w.sport = '1; w.dport = '1;
        w.act = 2'd3; w.spi = 32'h1234;
        rows.push_back('{w: w, typed: 0, want: '{default: 0}});
        w.op = OP_LOOKUP; w.proto = 8'hff; w.saddr = '1; w.daddr = 0; w.sport = 0;
        rows.push_back('{w: w, typed: 0, want: '{default: 0}});
        w.op = OP_APPEND; w.v6 = 0; w.act = 2'd1; w.spi = '1;
        rows.push_back('{w: w, typed: 0, want: '{default: 0}});
        rows.push_back('{w: blank(OP_CLEAR), typed: 1, want: '{ST_DONE, 0, 0, 0}});
        rows.push_back('{w: blank(OP_LOOKUP), typed: 1, want: '{ST_NOMATCH, 0, 0, 0}});

        foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);
        // Fill the table, then one more append must be refused.
        for (int i = 0; i < POLICY_DEPTH; i++) add_policy();
        send_word(noise(OP_APPEND), 1, '{ST_FULL, 0, 0, 0});

        k = 0;
        while (k < RANDOM_WORDS) begin
            if (!drained && k >= RANDOM_WORDS / 2) begin
                drained = 1;
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_verdicts.size() != 0) @(posedge aclk);
            end
            case ($urandom_range(0, 99)) inside
                [0:2]: begin
                    send_word(noise(OP_CLEAR), 0, '{default: 0});
                    k++;
                end
                [3:32]: begin
                    add_policy();
                    k += 2;
                end
                [33:37]: begin
                    send_word(noise($urandom_range(0, 1) ? OP_STAGE : OP_APPEND), 0,
                              '{default: 0});
                    k++;
                end
                default: begin
                    targeted_lookup();
                    k++;
                end
            endcase
        end
        s_tvalid <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (3 * POLICY_DEPTH) @(posedge aclk);
        $display("covered %0d words: %0d lookup hits, %0d misses, %0d refused appends",
                 n_words, n_hits, n_misses, n_full);
        $display("mismatches: %0d", errors);
        if (errors == 0) begin
            $display("ipsec_policy_classifier regression: pass");
        end else begin
            $display("ipsec_policy_classifier regression: fail");
        end
        $finish;
    end
endmodule
